// File: rtl/ned_pkg.sv
// shared constants, command and status types for the nearest exit distance block
`timescale 1ns / 1ps

package ned_pkg;

  localparam int MAX_EXIT_CELLS = 64;
  localparam int GRID_ROWS      = 256;
  localparam int GRID_COLUMNS   = 256;

  localparam int COORD_W = 8;
  localparam int CNT_W   = $clog2(MAX_EXIT_CELLS + 1);
  localparam int ADDR_W  = (MAX_EXIT_CELLS > 1) ? $clog2(MAX_EXIT_CELLS) : 1;

  localparam int OPCODE_W = 2;
  localparam int D2_W     = 17;
  localparam int DIST_W   = 17;
  localparam int RAD_W    = 2 * DIST_W;
  localparam int REM_W    = DIST_W + 3;
  localparam int ITER_W   = $clog2(DIST_W + 1);

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 24;

  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic scan_en;
    logic sqrt_load;
    logic out_load;
  } ned_cmd_t;

  typedef struct packed {
    logic special;
    logic scan_busy;
    logic sqrt_done;
    logic out_free;
  } ned_status_t;

endpackage

// File: rtl/ned_ctrl.sv
// controller state machine: handshake, scan and square root sequencing
`timescale 1ns / 1ps

module ned_ctrl import ned_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [OPCODE_W-1:0] opcode,
  output logic                s_tready,
  input  ned_status_t         status,
  output ned_cmd_t            cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SQRT,
    DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (accept) begin
          case (opcode)
            OP_CLEAR:  cmd.clear = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_QUERY: begin
              cmd.query_start = 1'b1;
              state_next      = SCAN;
            end
            default: ;
          endcase
        end
      end
      SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.special) begin
          state_next = DONE;
        end else if (!status.scan_busy) begin
          cmd.sqrt_load = 1'b1;
          state_next    = SQRT;
        end
      end
      SQRT: begin
        if (status.sqrt_done) begin
          state_next = DONE;
        end
      end
      DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/ned_datapath.sv
// datapath: exit store, distance scan, bit-serial square root, output register
`timescale 1ns / 1ps

module ned_datapath import ned_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [COORD_W-1:0]   row,
  input  logic [COORD_W-1:0]   column,
  input  logic                 cell_blocked,
  input  ned_cmd_t             cmd,
  output ned_status_t          status,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [DIST_W-1:0]    distance_q8,
  output logic                 distance_valid
);

  logic [2*COORD_W-1:0] exit_store [MAX_EXIT_CELLS];

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic                 in_grid;
  logic [COORD_W-1:0]   q_row;
  logic [COORD_W-1:0]   q_column;
  logic                 q_blocked;
  logic                 q_inside;

  logic                 issue;
  logic                 v1;
  logic                 v2;
  logic [2*COORD_W-1:0] rd_data;
  logic [COORD_W-1:0]   dr;
  logic [COORD_W-1:0]   dc;
  logic [D2_W-1:0]      d2;
  logic [D2_W-1:0]      d2_next;
  logic [D2_W-1:0]      best;

  logic [RAD_W-1:0]     rad;
  logic [REM_W-1:0]     rem;
  logic [DIST_W-1:0]    root;
  logic [ITER_W-1:0]    iter;
  logic [REM_W-1:0]     rem_shift;
  logic [REM_W-1:0]     trial;

  assign in_grid = ({1'b0, row} < (COORD_W+1)'(GRID_ROWS)) &&
                   ({1'b0, column} < (COORD_W+1)'(GRID_COLUMNS));

  assign issue = cmd.scan_en && (idx < count);

  // stored word: row in the low byte, column in the high byte
  always_comb begin
    logic [COORD_W-1:0] er;
    logic [COORD_W-1:0] ec;
    er = rd_data[COORD_W-1:0];
    ec = rd_data[2*COORD_W-1:COORD_W];
    dr = (er > q_row) ? (er - q_row) : (q_row - er);
    dc = (ec > q_column) ? (ec - q_column) : (q_column - ec);
    d2_next = D2_W'({{COORD_W{1'b0}}, dr} * {{COORD_W{1'b0}}, dr}) +
              D2_W'({{COORD_W{1'b0}}, dc} * {{COORD_W{1'b0}}, dc});
  end

  always_comb begin
    rem_shift = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial     = {1'b0, root, 2'b01};
  end

  assign status.special   = q_blocked || !q_inside || (count == '0);
  assign status.scan_busy = issue || v1 || v2;
  assign status.sqrt_done = (iter == '0);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.append && in_grid && (count < CNT_W'(MAX_EXIT_CELLS))) begin
      exit_store[count[ADDR_W-1:0]] <= {column, row};
    end
    rd_data <= exit_store[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      iter     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && in_grid && (count < CNT_W'(MAX_EXIT_CELLS))) begin
        count <= count + 1'b1;
      end

      if (cmd.query_start) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      v1 <= issue;
      v2 <= v1;

      if (cmd.sqrt_load) begin
        iter <= ITER_W'(DIST_W);
      end else if (iter != '0) begin
        iter <= iter - 1'b1;
      end

      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_row     <= row;
      q_column  <= column;
      q_blocked <= cell_blocked;
      q_inside  <= in_grid;
      best      <= '1;
    end else if (v2 && (d2 < best)) begin
      best <= d2;
    end
    if (v1) begin
      d2 <= d2_next;
    end

    // two radicand bits per step, one root bit out
    if (cmd.sqrt_load) begin
      rad  <= {1'b0, best, 16'd0};
      rem  <= '0;
      root <= '0;
    end else if (iter != '0) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[DIST_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[DIST_W-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      distance_q8    <= status.special ? '0 : root;
      distance_valid <= !status.special;
    end
  end

endmodule

// File: rtl/nearest_exit_distance_core.sv
// A query scans all N stored exits, then takes the square root; a blocked or empty query goes straight to the output
// Scan reads one stored exit per cycle from the store's single read port, then 17 root steps
// Clear and append leave the input ready; a query holds the input off until its word is loaded into the output register
// The input is taken again while a finished word waits in the output register
// Reset: synchronous, clears the exit count, the controller and the output valid; no sweep
`timescale 1ns / 1ps

module nearest_exit_distance_core import ned_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // row[7:0], column[15:8], cell_blocked[16], zero pad
  input  logic [OPCODE_W-1:0]  s_tuser,   // opcode[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // distance_q8[16:0], zero pad
  output logic                 m_tuser    // distance_valid
);

  ned_cmd_t          cmd;
  ned_status_t       status;
  logic [DIST_W-1:0] distance_q8;

  ned_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ned_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .row            (s_tdata[COORD_W-1:0]),
    .column         (s_tdata[2*COORD_W-1:COORD_W]),
    .cell_blocked   (s_tdata[2*COORD_W]),
    .cmd            (cmd),
    .status         (status),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .distance_q8    (distance_q8),
    .distance_valid (m_tuser)
  );

  assign m_tdata = {(M_TDATA_W-DIST_W)'(0), distance_q8};

endmodule

// File: rtl/ned_checker.sv
// port-level checker for the nearest exit distance core, with its bind
`timescale 1ns / 1ps

module ned_checker import ned_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [OPCODE_W-1:0]  s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // a waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // invalid distance carries zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid result with nonzero distance");

  // pad bits above the distance stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:DIST_W] == '0)
    else $error("output pad bits set");

  // a query takes the input side away for its scan
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_QUERY |=> !s_tready)
    else $error("input ready right after a query");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind nearest_exit_distance_core ned_checker u_ned_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: dv/tb.sv
// self-checking testbench for the nearest exit distance core: directed table, fill, random runs
`timescale 1ns / 1ps

module tb;
  import ned_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_MAX     = 13;
  localparam int RANDOM_ITEMS  = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int DRAIN_CYCLES  = 120;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [7:0]          row;
    logic [7:0]          col;
    logic                blk;
    logic                typed;
    logic                exp_valid;
    logic [DIST_W-1:0]   exp_dist;
  } dir_step_t;

  typedef struct {
    logic [DIST_W-1:0] dist_q8;
    logic              valid;
  } dist_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // row[7:0], column[15:8], cell_blocked[16], zero pad
  logic [OPCODE_W-1:0]  s_tuser = OP_CLEAR;   // opcode[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;   // distance_q8[16:0], zero pad
  logic                 m_tuser;   // distance_valid

  // exit table as the block should hold it
  logic [7:0] exit_rows [MAX_EXIT_CELLS];
  logic [7:0] exit_cols [MAX_EXIT_CELLS];
  int         exit_count = 0;

  dist_word_t expected_dists [$];
  int         errors = 0;
  int         items_sent = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  int         quiet_cycles = 0;

  // distances readable at a glance are typed in, the rest come from the predictor
  dir_step_t directed_steps [0:20] = '{
    '{OP_QUERY,  8'd0,   8'd0,   1'b0, 1'b1, 1'b0, 17'd0},      // empty after reset
    '{OP_APPEND, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0, 17'd0},      // blocked flag ignored
    '{OP_QUERY,  8'd0,   8'd0,   1'b0, 1'b1, 1'b1, 17'd0},
    '{OP_QUERY,  8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 17'd0},      // longest diagonal
    '{OP_QUERY,  8'd0,   8'd0,   1'b1, 1'b1, 1'b0, 17'd0},      // blocked cell
    '{OP_UNUSED, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, 17'd0},
    '{OP_APPEND, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 17'd0},
    '{OP_QUERY,  8'd255, 8'd0,   1'b0, 1'b1, 1'b1, 17'd65280},
    '{OP_QUERY,  8'd0,   8'd255, 1'b0, 1'b1, 1'b1, 17'd65280},
    '{OP_QUERY,  8'd128, 8'd128, 1'b0, 1'b0, 1'b0, 17'd0},
    '{OP_APPEND, 8'd3,   8'd4,   1'b0, 1'b0, 1'b0, 17'd0},
    '{OP_QUERY,  8'd6,   8'd8,   1'b0, 1'b1, 1'b1, 17'd1280},
    '{OP_CLEAR,  8'd170, 8'd85,  1'b1, 1'b0, 1'b0, 17'd0},
    '{OP_QUERY,  8'd3,   8'd4,   1'b0, 1'b1, 1'b0, 17'd0},      // empty after clear
    '{OP_APPEND, 8'd85,  8'd170, 1'b0, 1'b0, 1'b0, 17'd0},
    '{OP_APPEND, 8'd170, 8'd85,  1'b1, 1'b0, 1'b0, 17'd0},
    '{OP_QUERY,  8'd85,  8'd85,  1'b0, 1'b1, 1'b1, 17'd21760},
    '{OP_UNUSED, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 17'd0},      // must leave table alone
    '{OP_QUERY,  8'd170, 8'd170, 1'b0, 1'b1, 1'b1, 17'd21760},
    '{OP_QUERY,  8'd1,   8'd1,   1'b0, 1'b0, 1'b0, 17'd0},
    '{OP_CLEAR,  8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 17'd0}
  };

  nearest_exit_distance_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor of the square root, built one result bit at a time from the top
  function automatic logic [DIST_W-1:0] root_q8(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res[DIST_W-1:0];
  endfunction

  function automatic void predict_distance(input logic [OPCODE_W-1:0] op,
                                           input logic [7:0] row, input logic [7:0] col,
                                           input logic blk, output bit has_word,
                                           output dist_word_t word);
    bit          on_grid;
    int          best;
    int          dr;
    int          dc;
    logic [63:0] scaled;
    on_grid = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLUMNS);
    has_word = 1'b0;
    word.dist_q8 = '0;
    word.valid = 1'b0;
    case (op)
      OP_CLEAR: begin
        exit_count = 0;
      end
      OP_APPEND: begin
        if (on_grid && exit_count < MAX_EXIT_CELLS) begin
          exit_rows[exit_count] = row;
          exit_cols[exit_count] = col;
          exit_count++;
        end
      end
      OP_QUERY: begin
        has_word = 1'b1;
        if (!blk && on_grid && exit_count != 0) begin
          best = 32'h7fffffff;
          for (int k = 0; k < exit_count; k++) begin
            dr = int'(exit_rows[k]) - int'(row);
            dc = int'(exit_cols[k]) - int'(col);
            if (dr * dr + dc * dc < best) best = dr * dr + dc * dc;
          end
          scaled = 64'(best) << 16;
          word.dist_q8 = root_q8(scaled);
          word.valid = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [7:0] row,
                           input logic [7:0] col, input logic blk, input logic typed,
                           input logic exp_valid, input logic [DIST_W-1:0] exp_dist);
    int                   gap;
    logic [S_TDATA_W-1:0] w;
    bit                   has_word;
    dist_word_t           word;
    gap = tx_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w = '0;
    w[7:0] = row;
    w[15:8] = col;
    w[16] = blk;
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_distance(op, row, col, blk, has_word, word);
    if (has_word) begin
      if (typed) begin
        word.dist_q8 = exp_dist;
        word.valid = exp_valid;
      end
      expected_dists.push_back(word);
    end
    if (op != OP_UNUSED) items_sent++;
  endtask

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(input logic [OPCODE_W-1:0] op, input logic blk);
    send_word(op, pick_coord(), pick_coord(), blk, 1'b0, 1'b0, '0);
  endtask

  // sender holds off until every pending distance word is back
  task automatic drain_pause();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_dists.size() != 0) @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int n;
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i])
      send_word(directed_steps[i].op, directed_steps[i].row, directed_steps[i].col,
                directed_steps[i].blk, directed_steps[i].typed,
                directed_steps[i].exp_valid, directed_steps[i].exp_dist);

    // fill past capacity, then query the full table
    tx_calm = 1'b1;
    send_random(OP_CLEAR, 1'b0);
    for (int k = 0; k < MAX_EXIT_CELLS + 3; k++) send_random(OP_APPEND, 1'($urandom_range(0, 1)));
    send_word(OP_QUERY, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, '0);
    send_word(OP_QUERY, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, '0);
    drain_pause();

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 8) drain_pause();
      if ($urandom_range(0, 9) == 0) begin
        // noise: any opcode, any field bits
        n = $urandom_range(4, 10);
        repeat (n)
          send_word(OP_CLEAR + 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                    1'($urandom), 1'b0, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 2) == 0) send_random(OP_CLEAR, 1'($urandom_range(0, 1)));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (n) send_random(OP_APPEND, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 6);
        repeat (n) send_random(OP_QUERY, ($urandom_range(0, 5) == 0));
      end
      phase++;
    end
    s_tvalid <= 1'b0;

    while (expected_dists.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // result side: random stalls, each word checked against the oldest expectation
  initial begin
    int         stall;
    dist_word_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_dists.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual dist %0d valid %0b",
                 $time, m_tdata[DIST_W-1:0], m_tuser);
        errors++;
      end else begin
        want = expected_dists.pop_front();
        if (m_tdata[DIST_W-1:0] !== want.dist_q8) begin
          $display("%0t: distance_q8 mismatch, expected %0d, actual %0d",
                   $time, want.dist_q8, m_tdata[DIST_W-1:0]);
          errors++;
        end
        if (m_tuser !== want.valid) begin
          $display("%0t: distance_valid mismatch, expected %0b, actual %0b",
                   $time, want.valid, m_tuser);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("%0t: watchdog expired, %0d words outstanding",
                 $time, expected_dists.size());
        $display("tb failed");
        $finish;
      end
    end
  end

endmodule
